### rtl/spa_pkg.sv
// ----------------------------------------------------------------------------
// spa_pkg
// Shared types and codes for the slot pool allocator: command and status
// codes, slot states, the decoded operation carried through the queue and
// the back-end sequencer states.
// ----------------------------------------------------------------------------
package spa_pkg;

   localparam int CMD_W  = 2;
   localparam int IDX_W  = 10;
   localparam int CNT_W  = 11;
   localparam int STAT_W = 2;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [CMD_W-1:0] CMD_CLAIM   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DESTROY = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

   localparam logic [STAT_W-1:0] STAT_DONE      = 2'd0;
   localparam logic [STAT_W-1:0] STAT_EXHAUSTED = 2'd1;
   localparam logic [STAT_W-1:0] STAT_IGNORED   = 2'd2;

   localparam logic [CNT_W-1:0] CAP_RESET = 11'd1024;

   typedef enum logic [1:0] {
      SLOT_FREE = 2'd0,
      SLOT_LIVE = 2'd1,
      SLOT_DEAD = 2'd2
   } slot_state_type;

   typedef enum logic [1:0] {
      OP_CLAIM,
      OP_DESTROY,
      OP_RELEASE,
      OP_IGNORE
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [IDX_W-1:0]   idx;
   } work_type;

   typedef enum logic {
      BK_IDLE,
      BK_EXEC
   } back_state_type;

endpackage

### rtl/spa_front.sv
// ----------------------------------------------------------------------------
// spa_front
// Request decoder: turns a command and handle into one queued operation.
// Destroy or release with a null handle, and the unused command code, collapse into an ignore.
// ----------------------------------------------------------------------------
module spa_front (
   input  logic [spa_pkg::CMD_W-1:0] req_command,
   input  logic                      req_handle_present,
   input  logic [spa_pkg::IDX_W-1:0] req_slot_index,
   output spa_pkg::work_type         work
);
   import spa_pkg::*;

   always_comb begin
      work.idx = req_slot_index;
      unique case (req_command)
         CMD_CLAIM: begin
            work.op = OP_CLAIM;
         end
         CMD_DESTROY: begin
            work.op = req_handle_present ? OP_DESTROY : OP_IGNORE;
         end
         CMD_RELEASE: begin
            work.op = req_handle_present ? OP_RELEASE : OP_IGNORE;
         end
         default: begin
            work.op = OP_IGNORE;
         end
      endcase
   end

endmodule

### rtl/spa_queue.sv
// ----------------------------------------------------------------------------
// spa_queue
// Short FIFO of decoded operations between the front end and the back end.
// ----------------------------------------------------------------------------
module spa_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  spa_pkg::work_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output spa_pkg::work_type pop_data
);
   import spa_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   work_type           entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]     count_ff, count_in;
   logic               push, pop;

   assign push_ready = (count_ff != (PTR_W+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/spa_back.sv
// ----------------------------------------------------------------------------
// spa_back
// Execution back end: reads slot state and the free-list link, then commits
// the update to the memories, the free-list head, the counters and the
// response register. One operation is in flight at a time.
// ----------------------------------------------------------------------------
module spa_back #(
   parameter int SLOTS = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [spa_pkg::CNT_W-1:0]  csr_wr_data,
   input  logic                       work_valid,
   output logic                       work_ready,
   input  spa_pkg::work_type          work_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [spa_pkg::STAT_W-1:0] rsp_status,
   output logic [spa_pkg::IDX_W-1:0]  rsp_granted_slot,
   output logic [spa_pkg::CNT_W-1:0]  rsp_live_count
);
   import spa_pkg::*;

   localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int XW = (AW + 1 > CNT_W) ? AW + 1 : CNT_W;

   back_state_type     state_ff, state_in;
   logic [CNT_W-1:0]   cap_ff;
   logic [CNT_W-1:0]   fresh_ff, fresh_in;
   logic [CNT_W-1:0]   live_ff, live_in;
   logic [AW-1:0]      head_ff, head_in;
   logic               empty_ff, empty_in;
   work_type           job_ff;
   slot_state_type     st_rd_ff;
   logic [AW-1:0]      link_rd_ff;

   logic               rsp_valid_ff;
   logic [STAT_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]   rsp_slot_ff, rsp_slot_in;

   slot_state_type     status_mem [SLOTS];
   logic [AW-1:0]      link_mem [SLOTS];

   logic               pop, commit;
   logic [XW-1:0]      cap_x, limit_x, fresh_x;
   logic               fresh_avail, idx_ok;
   logic [AW-1:0]      job_addr, claim_slot;
   logic               st_we, link_we;
   logic [AW-1:0]      st_addr;
   slot_state_type     st_wdata;
   logic [AW-1:0]      link_wdata;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (work_valid) begin
               state_in = BK_EXEC;
            end
         end
         BK_EXEC: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // Sequencer outputs
   always_comb begin
      pop    = 1'b0;
      commit = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            pop = work_valid;
         end
         BK_EXEC: begin
            commit = !rsp_valid_ff || rsp_ready;
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   assign work_ready = pop;

   // Slots at or above the fresh count were never written; the count gates reads.
   assign cap_x       = XW'(cap_ff);
   assign limit_x     = (cap_x < XW'(SLOTS)) ? cap_x : XW'(SLOTS);
   assign fresh_x     = XW'(fresh_ff);
   assign fresh_avail = fresh_x < limit_x;
   assign idx_ok      = XW'(job_ff.idx) < fresh_x;
   assign job_addr    = AW'(job_ff.idx);

   always_comb begin
      fresh_in      = fresh_ff;
      live_in       = live_ff;
      head_in       = head_ff;
      empty_in      = empty_ff;
      rsp_status_in = STAT_IGNORED;
      rsp_slot_in   = '0;
      claim_slot    = head_ff;
      st_we         = 1'b0;
      st_addr       = job_addr;
      st_wdata      = SLOT_FREE;
      link_we       = 1'b0;
      link_wdata    = empty_ff ? job_addr : head_ff;
      case (job_ff.op)
         OP_CLAIM: begin
            if (!empty_ff) begin
               claim_slot = head_ff;
               if (link_rd_ff == head_ff) begin
                  empty_in = 1'b1;
               end else begin
                  head_in = link_rd_ff;
               end
            end else begin
               claim_slot = AW'(fresh_ff);
               fresh_in   = fresh_ff + 1'b1;
            end
            if (!empty_ff || fresh_avail) begin
               st_we         = 1'b1;
               st_addr       = claim_slot;
               st_wdata      = SLOT_LIVE;
               live_in       = live_ff + 1'b1;
               rsp_status_in = STAT_DONE;
               rsp_slot_in   = IDX_W'(claim_slot);
            end else begin
               fresh_in      = fresh_ff;
               rsp_status_in = STAT_EXHAUSTED;
            end
         end
         OP_DESTROY: begin
            if (idx_ok && st_rd_ff == SLOT_LIVE) begin
               st_we         = 1'b1;
               st_wdata      = SLOT_DEAD;
               rsp_status_in = STAT_DONE;
            end
         end
         OP_RELEASE: begin
            if (idx_ok && st_rd_ff != SLOT_FREE) begin
               st_we         = 1'b1;
               st_wdata      = SLOT_FREE;
               link_we       = 1'b1;
               head_in       = job_addr;
               empty_in      = 1'b0;
               live_in       = (live_ff != '0) ? live_ff - 1'b1 : live_ff;
               rsp_status_in = STAT_DONE;
            end
         end
         default: begin
            rsp_status_in = STAT_IGNORED;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         cap_ff       <= CAP_RESET;
         fresh_ff     <= '0;
         live_ff      <= '0;
         head_ff      <= '0;
         empty_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            // empty the pool
            cap_ff   <= csr_wr_data;
            fresh_ff <= '0;
            live_ff  <= '0;
            head_ff  <= '0;
            empty_ff <= 1'b1;
         end else if (commit) begin
            fresh_ff <= fresh_in;
            live_ff  <= live_in;
            head_ff  <= head_in;
            empty_ff <= empty_in;
         end
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         job_ff <= work_data;
      end
      if (commit) begin
         rsp_status_ff <= rsp_status_in;
         rsp_slot_ff   <= rsp_slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         st_rd_ff <= status_mem[AW'(work_data.idx)];
      end
      if (commit && st_we) begin
         status_mem[st_addr] <= st_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         link_rd_ff <= link_mem[head_ff];
      end
      if (commit && link_we) begin
         link_mem[job_addr] <= link_wdata;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_granted_slot = rsp_slot_ff;
   assign rsp_live_count   = live_ff;

endmodule

### rtl/slot_pool_allocator.sv
// ----------------------------------------------------------------------------
// slot_pool_allocator
// Slot allocator with a LIFO free list, a fresh-slot counter and per-slot
// free/live/destroyed state. Requests are decoded, queued, then executed.
// ----------------------------------------------------------------------------
// Flow: an accepted request is queued, then popped by the back end in idle,
//   which reads the slot state and free-list link memories; the update is
//   committed in execute. No new operation is taken before the commit.
// Reset: control state clears, capacity returns to 1024 and the pool is empty;
//   the memories are not cleared, the fresh-slot count marks written entries.
module slot_pool_allocator #(
   parameter int SLOTS = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [spa_pkg::CMD_W-1:0]  req_command,
   input  logic                       req_handle_present,
   input  logic [spa_pkg::IDX_W-1:0]  req_slot_index,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [spa_pkg::STAT_W-1:0] rsp_status,
   output logic [spa_pkg::IDX_W-1:0]  rsp_granted_slot,
   output logic [spa_pkg::CNT_W-1:0]  rsp_live_count,
   input  logic                       csr_wr_en,
   input  logic [spa_pkg::CNT_W-1:0]  csr_wr_data
);
   import spa_pkg::*;

   work_type   front_work;
   work_type   queue_work;
   logic       queue_valid;
   logic       queue_pop;

   spa_front u_front (
      .req_command        (req_command),
      .req_handle_present (req_handle_present),
      .req_slot_index     (req_slot_index),
      .work               (front_work)
   );

   spa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_data  (front_work),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_pop),
      .pop_data   (queue_work)
   );

   spa_back #(
      .SLOTS (SLOTS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .work_valid       (queue_valid),
      .work_ready       (queue_pop),
      .work_data        (queue_work),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_granted_slot (rsp_granted_slot),
      .rsp_live_count   (rsp_live_count)
   );

endmodule

### rtl/spa_checker.sv
// ----------------------------------------------------------------------------
// spa_checker
// Port-level checks for the slot pool allocator, bound to the top level.
// ----------------------------------------------------------------------------
module spa_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic [spa_pkg::STAT_W-1:0] rsp_status,
   input  logic [spa_pkg::IDX_W-1:0]  rsp_granted_slot,
   input  logic [spa_pkg::CNT_W-1:0]  rsp_live_count
);
   import spa_pkg::*;

   // a response that is not done never carries a slot
   a_slot_only_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_DONE |-> rsp_granted_slot == '0)
      else $error("granted slot nonzero on a response that is not done");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STAT_DONE || rsp_status == STAT_EXHAUSTED
                     || rsp_status == STAT_IGNORED))
      else $error("response status outside the defined codes");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
                                  && $stable(rsp_granted_slot)
                                  && $stable(rsp_live_count))
      else $error("stalled response changed");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && rsp_live_count == '0)
      else $error("response or live count not cleared by reset");

endmodule

bind slot_pool_allocator spa_checker u_spa_checker (.*);
